@@ design/mpq_pkg.sv @@
// Package for the minimum priority queue: operation codes and field widths.
// No dependencies.
`timescale 1ns / 1ps

package mpq_pkg;

   localparam int KEY_BITS  = 32;
   localparam int WORD_BITS = 32;
   localparam int OCC_BITS  = 5;

   typedef logic [1:0] op_type;

   localparam op_type OP_INSERT = 2'd0;
   localparam op_type OP_REMOVE = 2'd1;
   localparam op_type OP_PEEK   = 2'd2;

endpackage

@@ design/mpq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mpq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/min_priority_queue.sv @@
// Minimum priority queue: entries kept in age order in one RAM, min found by a serial scan.
// Depends on mpq_pkg and mpq_ram.
// Peek and remove scan all N stored entries; remove then shifts the S newer entries behind
// the minimum down by one place (one move per cycle). Insert and no-op skip the scan.
// Throughput: one item at a time, the scan compares one stored key per cycle.
// Reset: synchronous, empties the queue, no clearing pass.
`timescale 1ns / 1ps

module min_priority_queue #(
   parameter int CAPACITY     = 16,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_operation,
   input  logic signed [mpq_pkg::KEY_BITS-1:0]  req_key,
   input  logic [mpq_pkg::WORD_BITS-1:0]        req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_found,
   output logic signed [mpq_pkg::KEY_BITS-1:0]  rsp_out_key,
   output logic [mpq_pkg::WORD_BITS-1:0]        rsp_out_payload,
   output logic                                 rsp_rejected,
   output logic [mpq_pkg::OCC_BITS-1:0]         rsp_occupancy,
   output logic                                 rsp_is_empty
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int EXT_W = CNT_W + 1;
   localparam int PL_W  = (PAYLOAD_BITS < mpq_pkg::WORD_BITS) ? PAYLOAD_BITS
                                                                : mpq_pkg::WORD_BITS;
   localparam int RAM_W = mpq_pkg::KEY_BITS + PL_W;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_SHIFT = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]                          state_ff, state_in;
   logic [CNT_W-1:0]                    count_ff, count_in;
   logic [IDX_W-1:0]                    pos_ff, pos_in;
   logic [IDX_W-1:0]                    best_pos_ff, best_pos_in;
   logic signed [mpq_pkg::KEY_BITS-1:0] best_key_ff, best_key_in;
   logic [PL_W-1:0]                     best_pay_ff, best_pay_in;
   logic                                remove_ff, remove_in;
   logic                                found_ff, found_in;
   logic                                rej_ff, rej_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_found_ff, rsp_found_in;
   logic signed [mpq_pkg::KEY_BITS-1:0] rsp_key_ff, rsp_key_in;
   logic [mpq_pkg::WORD_BITS-1:0]       rsp_pay_ff, rsp_pay_in;
   logic                                rsp_rej_ff, rsp_rej_in;
   logic [mpq_pkg::OCC_BITS-1:0]        rsp_occ_ff, rsp_occ_in;
   logic                                rsp_empty_ff, rsp_empty_in;

   logic                                wr_en;
   logic [IDX_W-1:0]                    wr_addr;
   logic [RAM_W-1:0]                    wr_data;
   logic                                rd_en;
   logic [IDX_W-1:0]                    rd_addr;
   logic [RAM_W-1:0]                    rd_data;

   logic                                accept;
   logic                                full;
   logic signed [mpq_pkg::KEY_BITS-1:0] rd_key;
   logic [PL_W-1:0]                     rd_pay;
   logic [EXT_W-1:0]                    count_ext;
   logic [EXT_W-1:0]                    pos_ext;
   logic [EXT_W-1:0]                    best_next_ext;
   logic                                take;
   logic                                scan_last;

   assign req_ready     = (state_ff == ST_IDLE);
   assign accept        = req_valid && req_ready;
   assign full          = (count_ff == CNT_W'(CAPACITY));
   assign rd_key        = rd_data[RAM_W-1 -: mpq_pkg::KEY_BITS];
   assign rd_pay        = rd_data[PL_W-1:0];
   assign count_ext     = EXT_W'(count_ff);
   assign pos_ext       = EXT_W'(pos_ff);
   assign take          = (pos_ff == '0) || (rd_key <= best_key_ff);
   assign scan_last     = (pos_ext + EXT_W'(1) == count_ext);
   assign best_next_ext = EXT_W'(best_pos_in) + EXT_W'(1);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      best_pos_in  = best_pos_ff;
      best_key_in  = best_key_ff;
      best_pay_in  = best_pay_ff;
      remove_in    = remove_ff;
      found_in     = found_ff;
      rej_in       = rej_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = rd_data;
      rd_en        = 1'b0;
      rd_addr      = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_found_in = rsp_found_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_pay_in   = rsp_pay_ff;
      rsp_rej_in   = rsp_rej_ff;
      rsp_occ_in   = rsp_occ_ff;
      rsp_empty_in = rsp_empty_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               found_in  = 1'b0;
               rej_in    = 1'b0;
               remove_in = (req_operation == mpq_pkg::OP_REMOVE);
               state_in  = ST_DONE;
               if (req_operation == mpq_pkg::OP_INSERT) begin
                  if (full) begin
                     rej_in = 1'b1;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = IDX_W'(count_ff);
                     wr_data  = {req_key, req_payload[PL_W-1:0]};
                     count_in = count_ff + CNT_W'(1);
                  end
               end else if ((req_operation == mpq_pkg::OP_REMOVE ||
                             req_operation == mpq_pkg::OP_PEEK) && count_ff != '0) begin
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  pos_in   = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (take) begin
               best_pos_in = pos_ff;
               best_key_in = rd_key;
               best_pay_in = rd_pay;
            end
            if (!scan_last) begin
               rd_en   = 1'b1;
               rd_addr = IDX_W'(pos_ext + EXT_W'(1));
               pos_in  = IDX_W'(pos_ext + EXT_W'(1));
            end else begin
               found_in = 1'b1;
               if (!remove_ff) begin
                  state_in = ST_DONE;
               end else if (best_next_ext == count_ext) begin
                  count_in = count_ff - CNT_W'(1);
                  state_in = ST_DONE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = IDX_W'(best_next_ext);
                  pos_in   = best_pos_in;
                  state_in = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff;
            wr_data = rd_data;
            pos_in  = IDX_W'(pos_ext + EXT_W'(1));
            if (pos_ext + EXT_W'(2) < count_ext) begin
               rd_en   = 1'b1;
               rd_addr = IDX_W'(pos_ext + EXT_W'(2));
            end else begin
               count_in = count_ff - CNT_W'(1);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_key_in   = found_ff ? best_key_ff : '0;
               rsp_pay_in   = found_ff ? mpq_pkg::WORD_BITS'(best_pay_ff) : '0;
               rsp_rej_in   = rej_ff;
               rsp_occ_in   = mpq_pkg::OCC_BITS'(count_ff);
               rsp_empty_in = (count_ff == '0);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      best_pos_ff  <= best_pos_in;
      best_key_ff  <= best_key_in;
      best_pay_ff  <= best_pay_in;
      remove_ff    <= remove_in;
      found_ff     <= found_in;
      rej_ff       <= rej_in;
      rsp_found_ff <= rsp_found_in;
      rsp_key_ff   <= rsp_key_in;
      rsp_pay_ff   <= rsp_pay_in;
      rsp_rej_ff   <= rsp_rej_in;
      rsp_occ_ff   <= rsp_occ_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   mpq_ram #(
      .WIDTH (RAM_W),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_out_key     = rsp_key_ff;
   assign rsp_out_payload = rsp_pay_ff;
   assign rsp_rejected    = rsp_rej_ff;
   assign rsp_occupancy   = rsp_occ_ff;
   assign rsp_is_empty    = rsp_empty_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_found_not_rej: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_found_ff && rsp_rej_ff))
      else $error("result both found and rejected");

   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> (pos_ext + EXT_W'(1) < count_ext))
      else $error("shift past last entry");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (accept && req_operation == mpq_pkg::OP_INSERT && !full)
      |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not grow the queue");
`endif

endmodule
